### sv/hkt_pkg.sv
// hkt_pkg: shared types, constants and helpers for the history/killer table.
// Used by hkt_front, hkt_back, history_killer_table and the sim files; no dependencies.
package hkt_pkg;

    // Default geometry, used as the defaults of the top level parameters
    localparam int PIECE_KINDS_DEF = 12;
    localparam int SQUARES_DEF     = 64;
    localparam int PLY_COUNT_DEF   = 64;
    localparam int MOVE_BITS_DEF   = 16;

    // Depth of the command queue and of the result queue
    localparam int CMD_Q_DEPTH = 2;
    localparam int RES_Q_DEPTH = 2;

    // Field widths fixed by the interface
    localparam int KIND_W  = 2;
    localparam int PIECE_W = 4;
    localparam int SQ_W    = 6;
    localparam int DEPTH_W = 6;
    localparam int PLY_W   = 6;
    localparam int SCORE_W = 24;
    localparam int LIMIT_W = 21;
    localparam int DELTA_W = 2 * DEPTH_W + 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16384);

    // Saturation bounds, one bit wider than a score
    localparam logic signed [SCORE_W:0] SUM_MAX = (SCORE_W+1)'(8388607);
    localparam logic signed [SCORE_W:0] SUM_MIN = -(SCORE_W+1)'(8388608);

    // Command codes carried on the kind field
    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR   = 2'd0,
        KIND_REWARD  = 2'd1,
        KIND_PENALTY = 2'd2,
        KIND_READ    = 2'd3
    } kind_t;

    // Classified command passed from the front to the back
    typedef struct packed {
        kind_t               op;
        logic                addr_ok;
        logic                ply_ok;
        logic [PIECE_W-1:0]  piece;
        logic [SQ_W-1:0]     to_square;
        logic [PLY_W-1:0]    ply;
        logic [DELTA_W-1:0]  delta;
    } cmd_t;

    // Halve a score, truncating toward zero
    function automatic logic signed [SCORE_W-1:0] halve_score(
        input logic signed [SCORE_W-1:0] v
    );
        logic signed [SCORE_W-1:0] adj;
        adj = v + SCORE_W'(v[SCORE_W-1]);
        return adj >>> 1;
    endfunction

endpackage

### sv/hkt_ram.sv
// hkt_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module hkt_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/hkt_fifo.sv
// hkt_fifo: small register-based queue with push/full and pop/empty sides.
// No dependencies.
module hkt_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entries_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNTW'(do_push) - CNTW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### sv/hkt_front.sv
// hkt_front: accepts input words, classifies them and queues commands for the back.
// Depends on hkt_pkg and hkt_fifo.
module hkt_front
    import hkt_pkg::*;
#(
    parameter int PIECE_KINDS = PIECE_KINDS_DEF,
    parameter int SQUARES     = SQUARES_DEF,
    parameter int PLY_COUNT   = PLY_COUNT_DEF,
    parameter int MOVE_BITS   = MOVE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [KIND_W-1:0]    kind,
    input  logic [PIECE_W-1:0]   piece,
    input  logic [SQ_W-1:0]      to_square,
    input  logic [MOVE_BITS-1:0] move_code,
    input  logic [DEPTH_W-1:0]   depth,
    input  logic [PLY_W-1:0]     ply,
    input  logic                 is_quiet,
    input  logic                 init_busy,
    output cmd_t                 cmd_out,
    output logic [MOVE_BITS-1:0] cmd_move,
    output logic                 cmd_empty,
    input  logic                 cmd_pop
);

    localparam int CMD_W = $bits(cmd_t);
    localparam int QW    = CMD_W + MOVE_BITS;

    cmd_t                 cmd_cls;
    logic [2*DEPTH_W-1:0] depth_sq;
    logic                 q_full;
    logic [QW-1:0]        q_rdata;

    assign depth_sq = depth * depth;

    // Classify the incoming word
    always_comb
    begin
        cmd_cls.addr_ok   = (32'(piece) < PIECE_KINDS) && (32'(to_square) < SQUARES);
        cmd_cls.ply_ok    = (32'(ply) < PLY_COUNT);
        cmd_cls.piece     = piece;
        cmd_cls.to_square = to_square;
        cmd_cls.ply       = ply;
        unique case (kind_t'(kind))
            KIND_CLEAR:
            begin
                cmd_cls.op    = KIND_CLEAR;
                cmd_cls.delta = '0;
            end
            KIND_REWARD:
            begin
                // a reward on a capture or special move behaves as a read
                cmd_cls.op    = is_quiet ? KIND_REWARD : KIND_READ;
                cmd_cls.delta = {depth_sq, 1'b0};
            end
            KIND_PENALTY:
            begin
                cmd_cls.op    = KIND_PENALTY;
                cmd_cls.delta = {1'b0, depth_sq};
            end
            default:
            begin
                cmd_cls.op    = KIND_READ;
                cmd_cls.delta = '0;
            end
        endcase
    end

    // Command queue between front and back
    hkt_fifo #(
        .WIDTH (QW),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !full),
        .wdata ({move_code, cmd_cls}),
        .full  (q_full),
        .pop   (cmd_pop),
        .rdata (q_rdata),
        .empty (cmd_empty)
    );

    // No words taken while the table is being cleared after reset
    assign full     = q_full || init_busy;
    assign cmd_out  = cmd_t'(q_rdata[CMD_W-1:0]);
    assign cmd_move = q_rdata[QW-1 -: MOVE_BITS];

endmodule

### sv/hkt_back.sv
// hkt_back: executes commands against the score and killer RAMs, runs clear and halve sweeps.
// Depends on hkt_pkg and hkt_ram.
module hkt_back
    import hkt_pkg::*;
#(
    parameter int PIECE_KINDS = PIECE_KINDS_DEF,
    parameter int SQUARES     = SQUARES_DEF,
    parameter int PLY_COUNT   = PLY_COUNT_DEF,
    parameter int MOVE_BITS   = MOVE_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [LIMIT_W-1:0]             cfg_wdata,
    input  cmd_t                           cmd_in,
    input  logic [MOVE_BITS-1:0]           cmd_move,
    input  logic                           cmd_empty,
    output logic                           cmd_pop,
    output logic                           init_busy,
    output logic                           res_push,
    output logic [SCORE_W+2*MOVE_BITS:0]   res_data,
    input  logic                           res_full
);

    localparam int TBL = PIECE_KINDS * SQUARES;
    localparam int TAW = (TBL > 1) ? $clog2(TBL) : 1;
    localparam int CW  = $clog2(TBL + 1);
    localparam int PAW = (PLY_COUNT > 1) ? $clog2(PLY_COUNT) : 1;
    localparam int KW  = 2 * MOVE_BITS;

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_CLEAR = 5'b01000,
        ST_HALVE = 5'b10000
    } st_t;

    st_t                  state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [MOVE_BITS-1:0] move_reg, move_next;
    logic [TAW-1:0]       idx_reg, idx_next;
    logic [PAW-1:0]       pidx_reg, pidx_next;
    logic [PLY_COUNT-1:0] kvalid_reg, kvalid_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;

    // RAM ports
    logic                 s_we;
    logic [TAW-1:0]       s_waddr, s_raddr;
    logic [SCORE_W-1:0]   s_wdata, s_rdata;
    logic                 k_we;
    logic [KW-1:0]        k_wdata, k_rdata;

    // Datapath
    logic [TAW-1:0]              head_idx;
    logic [PAW-1:0]              head_pidx;
    logic signed [SCORE_W-1:0]   old_s, new_s, score_out;
    logic signed [SCORE_W:0]     old_ext, new_ext, dlt_ext, lim_ext, sum;
    logic                        mod_op, hv, score_wr;
    logic                        kv, kill_upd;
    logic [MOVE_BITS-1:0]        ka, kb, k1_out, k2_out;

    assign head_idx  = TAW'(32'(cmd_in.piece) * SQUARES + 32'(cmd_in.to_square));
    assign head_pidx = PAW'(cmd_in.ply);
    assign init_busy = (state_reg == ST_INIT);

    // Score read-modify-write with saturation and halving check
    always_comb
    begin
        old_s   = s_rdata;
        old_ext = {old_s[SCORE_W-1], old_s};
        dlt_ext = $signed({{(SCORE_W+1-DELTA_W){1'b0}}, cmd_reg.delta});
        lim_ext = $signed({{(SCORE_W+1-LIMIT_W){1'b0}}, limit_reg});
        case (cmd_reg.op)
            KIND_REWARD:  sum = old_ext + dlt_ext;
            KIND_PENALTY: sum = old_ext - dlt_ext;
            default:      sum = old_ext;
        endcase
        if (sum > SUM_MAX)
        begin
            new_s = SUM_MAX[SCORE_W-1:0];
        end
        else if (sum < SUM_MIN)
        begin
            new_s = SUM_MIN[SCORE_W-1:0];
        end
        else
        begin
            new_s = sum[SCORE_W-1:0];
        end
        new_ext  = {new_s[SCORE_W-1], new_s};
        mod_op   = (cmd_reg.op == KIND_REWARD) || (cmd_reg.op == KIND_PENALTY);
        score_wr = cmd_reg.addr_ok && mod_op;
        hv       = cmd_reg.addr_ok &&
                   (((cmd_reg.op == KIND_REWARD) && (new_ext >= lim_ext)) ||
                    ((cmd_reg.op == KIND_PENALTY) && (new_ext < -lim_ext)));
        if (!cmd_reg.addr_ok)
        begin
            score_out = '0;
        end
        else if (hv)
        begin
            score_out = halve_score(new_s);
        end
        else
        begin
            score_out = new_s;
        end
    end

    // Killer slot pair: invalid rows read as zero
    always_comb
    begin
        kv       = kvalid_reg[pidx_reg];
        ka       = kv ? k_rdata[KW-1 -: MOVE_BITS] : '0;
        kb       = kv ? k_rdata[MOVE_BITS-1:0] : '0;
        kill_upd = (cmd_reg.op == KIND_REWARD) && cmd_reg.ply_ok && (move_reg != ka);
        k1_out   = cmd_reg.ply_ok ? (kill_upd ? move_reg : ka) : '0;
        k2_out   = cmd_reg.ply_ok ? (kill_upd ? ka : kb) : '0;
        k_wdata  = {move_reg, ka};
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd_next    = cmd_reg;
        move_next   = move_reg;
        idx_next    = idx_reg;
        pidx_next   = pidx_reg;
        kvalid_next = kvalid_reg;
        limit_next  = cfg_we ? cfg_wdata : limit_reg;
        cmd_pop     = 1'b0;
        res_push    = 1'b0;
        res_data    = '0;
        s_we        = 1'b0;
        s_waddr     = cnt_reg[TAW-1:0];
        s_wdata     = '0;
        s_raddr     = head_idx;
        k_we        = 1'b0;
        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                // zero one score entry per cycle
                s_we     = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(TBL - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop   = 1'b1;
                    cmd_next  = cmd_in;
                    move_next = cmd_move;
                    idx_next  = head_idx;
                    pidx_next = head_pidx;
                    if (cmd_in.op == KIND_CLEAR)
                    begin
                        kvalid_next = '0;
                        res_push    = 1'b1;
                        cnt_next    = '0;
                        state_next  = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                res_push = 1'b1;
                res_data = {score_out, k1_out, k2_out, hv};
                s_we     = score_wr;
                s_waddr  = idx_reg;
                s_wdata  = new_s;
                k_we     = kill_upd;
                if (kill_upd)
                begin
                    kvalid_next[pidx_reg] = 1'b1;
                end
                if (hv)
                begin
                    cnt_next   = '0;
                    state_next = ST_HALVE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_HALVE:
            begin
                // read entry n while writing back entry n-1
                s_raddr  = (cnt_reg < CW'(TBL)) ? cnt_reg[TAW-1:0] : '0;
                s_we     = (cnt_reg != '0);
                s_waddr  = TAW'(cnt_reg - 1'b1);
                s_wdata  = halve_score(s_rdata);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(TBL))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            cnt_reg    <= '0;
            kvalid_reg <= '0;
            limit_reg  <= LIMIT_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            kvalid_reg <= kvalid_next;
            limit_reg  <= limit_next;
        end
    end

    // Command payload, no reset needed
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        move_reg <= move_next;
        idx_reg  <= idx_next;
        pidx_reg <= pidx_next;
    end

    hkt_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (TBL)
    ) u_score_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    hkt_ram #(
        .WIDTH (KW),
        .DEPTH (PLY_COUNT)
    ) u_killer_ram (
        .clk   (clk),
        .we    (k_we),
        .waddr (pidx_reg),
        .wdata (k_wdata),
        .raddr (head_pidx),
        .rdata (k_rdata)
    );

endmodule

### sv/history_killer_table.sv
// history_killer_table: top level of the history score table with killer moves.
// Depends on hkt_pkg, hkt_front, hkt_back and hkt_fifo.
//
// Move-ordering history table with two killer slots per ply. Input words are pushed
// into a two-entry command queue; results come out of a two-entry result queue in
// order, one result word per input word. A read, reward or penalty passes the back
// end in two steps: in the idle state it pops the command and reads the score and
// killer RAMs, in the exec state it updates, writes back and posts the result; the
// back end takes no new word until both steps are done. A clear posts its all-zero
// result at once, then zeroes the score RAM one entry a cycle. A word that trips the
// halving limit posts its (already halved) result, then the back end sweeps and
// halves the score RAM before the next word. After reset the score RAM is cleared,
// during which full stays high; hist_limit writes are taken at any time.
module history_killer_table
    import hkt_pkg::*;
#(
    parameter int PIECE_KINDS = PIECE_KINDS_DEF,
    parameter int SQUARES     = SQUARES_DEF,
    parameter int PLY_COUNT   = PLY_COUNT_DEF,
    parameter int MOVE_BITS   = MOVE_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // input side
    input  logic                        push,
    output logic                        full,
    input  logic [KIND_W-1:0]           kind,
    input  logic [PIECE_W-1:0]          piece,
    input  logic [SQ_W-1:0]             to_square,
    input  logic [MOVE_BITS-1:0]        move_code,
    input  logic [DEPTH_W-1:0]          depth,
    input  logic [PLY_W-1:0]            ply,
    input  logic                        is_quiet,
    // result side
    output logic                        empty,
    input  logic                        pop,
    output logic signed [SCORE_W-1:0]   score,
    output logic [MOVE_BITS-1:0]        killer_first,
    output logic [MOVE_BITS-1:0]        killer_second,
    output logic                        halved,
    // hist_limit register
    input  logic                        cfg_we,
    input  logic [LIMIT_W-1:0]          cfg_wdata
);

    localparam int RES_W = SCORE_W + 2 * MOVE_BITS + 1;

    cmd_t                 cmd_head;
    logic [MOVE_BITS-1:0] cmd_move;
    logic                 cmd_empty;
    logic                 cmd_pop;
    logic                 init_busy;
    logic                 res_push;
    logic                 res_full;
    logic [RES_W-1:0]     res_data;
    logic [RES_W-1:0]     res_head;

    // Front: accept and classify
    hkt_front #(
        .PIECE_KINDS (PIECE_KINDS),
        .SQUARES     (SQUARES),
        .PLY_COUNT   (PLY_COUNT),
        .MOVE_BITS   (MOVE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .piece     (piece),
        .to_square (to_square),
        .move_code (move_code),
        .depth     (depth),
        .ply       (ply),
        .is_quiet  (is_quiet),
        .init_busy (init_busy),
        .cmd_out   (cmd_head),
        .cmd_move  (cmd_move),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop)
    );

    // Back: execute against the tables
    hkt_back #(
        .PIECE_KINDS (PIECE_KINDS),
        .SQUARES     (SQUARES),
        .PLY_COUNT   (PLY_COUNT),
        .MOVE_BITS   (MOVE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_in    (cmd_head),
        .cmd_move  (cmd_move),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .init_busy (init_busy),
        .res_push  (res_push),
        .res_data  (res_data),
        .res_full  (res_full)
    );

    // Result queue decouples the back from the consumer
    hkt_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_head),
        .empty (empty)
    );

    assign score         = res_head[RES_W-1 -: SCORE_W];
    assign killer_first  = res_head[2*MOVE_BITS -: MOVE_BITS];
    assign killer_second = res_head[MOVE_BITS:1];
    assign halved        = res_head[0];

    // The back never posts a result word into a full result queue
    a_res_no_overflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full
    ) else $error("result word posted while result queue full");

    // Commands are only taken from a non-empty queue
    a_cmd_no_underflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty
    ) else $error("command popped from empty queue");

    // During the post-reset clear nothing enters or leaves the command queue
    a_init_quiet: assert property (
        @(posedge clk) disable iff (!rst_n)
        init_busy |-> (full && !cmd_pop && !res_push)
    ) else $error("activity during post-reset clear");

    // After a halved result word the back is sweeping and takes no command
    a_halve_after_post: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_push && res_data[0]) |=> !cmd_pop
    ) else $error("command taken right after a halving result");

endmodule

### sim/history_killer_table_check.sv
`timescale 1ns / 100ps
// history_killer_table_check: watches the word and result queues of the history table,
// predicts every result word from its own copy of scores, killers and limit, and counts
// mismatches. Depends on hkt_pkg.
module history_killer_table_check
    import hkt_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        full,
    input  logic [KIND_W-1:0]           kind,
    input  logic [PIECE_W-1:0]          piece,
    input  logic [SQ_W-1:0]             to_square,
    input  logic [MOVE_BITS_DEF-1:0]    move_code,
    input  logic [DEPTH_W-1:0]          depth,
    input  logic [PLY_W-1:0]            ply,
    input  logic                        is_quiet,
    input  logic                        empty,
    input  logic                        pop,
    input  logic signed [SCORE_W-1:0]   score,
    input  logic [MOVE_BITS_DEF-1:0]    killer_first,
    input  logic [MOVE_BITS_DEF-1:0]    killer_second,
    input  logic                        halved,
    input  logic                        cfg_we,
    input  logic [LIMIT_W-1:0]          cfg_wdata,
    output int                          errors,
    output int                          pending,
    output int                          results_seen
);

    localparam int TABLE_ENTRIES = PIECE_KINDS_DEF * SQUARES_DEF;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
    localparam int SCORE_TOP     = 8388607;
    localparam int SCORE_BOTTOM  = -8388608;

    typedef struct packed {
        logic signed [SCORE_W-1:0]  score;
        logic [MOVE_BITS_DEF-1:0]   first;
        logic [MOVE_BITS_DEF-1:0]   second;
        logic                       halved;
    } outcome_t;

    // Shadow state of the block
    logic signed [SCORE_W-1:0]  hist_score [TABLE_ENTRIES];
    logic [MOVE_BITS_DEF-1:0]   killer_a [PLY_COUNT_DEF];
    logic [MOVE_BITS_DEF-1:0]   killer_b [PLY_COUNT_DEF];
    logic [LIMIT_W-1:0]         limit_copy;
    outcome_t                   outcome_q [$];

    function automatic int saturate(input int v);
        if (v > SCORE_TOP)
            return SCORE_TOP;
        if (v < SCORE_BOTTOM)
            return SCORE_BOTTOM;
        return v;
    endfunction

    task automatic wipe_all();
        foreach (hist_score[i])
            hist_score[i] = '0;
        foreach (killer_a[i])
        begin
            killer_a[i] = '0;
            killer_b[i] = '0;
        end
    endtask

    // Integer division truncates toward zero, which is what the table does
    task automatic halve_table();
        foreach (hist_score[i])
            hist_score[i] = SCORE_W'(int'(hist_score[i]) / 2);
    endtask

    // Apply one word to the shadow state and work out its result word
    task automatic apply_word(
        input  kind_t                       op,
        input  logic [PIECE_W-1:0]          pc,
        input  logic [SQ_W-1:0]             sq,
        input  logic [MOVE_BITS_DEF-1:0]    mv,
        input  logic [DEPTH_W-1:0]          dp,
        input  logic [PLY_W-1:0]            pl,
        input  logic                        quiet,
        output outcome_t                    res
    );
        bit addr_ok;
        bit ply_ok;
        logic [SLOT_W-1:0] slot;
        int lim;
        int sq_depth;
        int sum;
        addr_ok  = (int'(pc) < PIECE_KINDS_DEF) && (int'(sq) < SQUARES_DEF);
        ply_ok   = int'(pl) < PLY_COUNT_DEF;
        slot     = addr_ok ? SLOT_W'(int'(pc) * SQUARES_DEF + int'(sq)) : '0;
        lim      = int'(limit_copy);
        sq_depth = int'(dp) * int'(dp);
        res      = '0;
        case (op)
            KIND_CLEAR:
                wipe_all();
            KIND_REWARD:
                if (quiet)
                begin
                    if (addr_ok)
                    begin
                        sum = saturate(int'(hist_score[slot]) + 2 * sq_depth);
                        hist_score[slot] = SCORE_W'(sum);
                        if (sum >= lim)
                        begin
                            halve_table();
                            res.halved = 1'b1;
                        end
                    end
                    // killer pair shifts only for a new move
                    if (ply_ok && mv != killer_a[pl])
                    begin
                        killer_b[pl] = killer_a[pl];
                        killer_a[pl] = mv;
                    end
                end
            KIND_PENALTY:
                if (addr_ok)
                begin
                    sum = saturate(int'(hist_score[slot]) - sq_depth);
                    hist_score[slot] = SCORE_W'(sum);
                    if (sum < -lim)
                    begin
                        halve_table();
                        res.halved = 1'b1;
                    end
                end
            default:
                ;
        endcase
        if (addr_ok)
            res.score = hist_score[slot];
        if (ply_ok)
        begin
            res.first  = killer_a[pl];
            res.second = killer_b[pl];
        end
    endtask

    task automatic report(input string field, input logic signed [31:0] want,
                          input logic signed [31:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    // Watch config writes, accepted words and accepted results
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            wipe_all();
            limit_copy   = LIMIT_RESET;
            outcome_q    = {};
            errors       = 0;
            pending      = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_we)
                limit_copy = cfg_wdata;
            if (push && !full)
            begin
                apply_word(kind_t'(kind), piece, to_square, move_code, depth, ply, is_quiet,
                           want);
                outcome_q.push_back(want);
            end
            if (pop && !empty)
            begin
                results_seen++;
                if (outcome_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with nothing expected", $time);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (score !== want.score)
                        report("score", want.score, score);
                    if (killer_first !== want.first)
                        report("killer_first", want.first, killer_first);
                    if (killer_second !== want.second)
                        report("killer_second", want.second, killer_second);
                    if (halved !== want.halved)
                        report("halved", want.halved, halved);
                end
            end
            pending = outcome_q.size();
        end
    end

endmodule

### sim/history_killer_table_test.sv
`timescale 1ns / 100ps
// history_killer_table_test: stimulus and verdict for the history/killer table.
// Depends on hkt_pkg, history_killer_table and history_killer_table_check.
module history_killer_table_test;
    import hkt_pkg::*;

    localparam int  SWEEP_WAIT   = PIECE_KINDS_DEF * SQUARES_DEF + 32;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  HOLD_AFTER   = 200;
    localparam real RUN_LIMIT_NS = 50_000_000.0;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    kind_t                      word_kind = KIND_READ;
    logic [PIECE_W-1:0]         piece = '0;
    logic [SQ_W-1:0]            to_square = '0;
    logic [MOVE_BITS_DEF-1:0]   move_code = '0;
    logic [DEPTH_W-1:0]         depth = '0;
    logic [PLY_W-1:0]           ply = '0;
    logic                       is_quiet = 1'b0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic signed [SCORE_W-1:0]  score;
    logic [MOVE_BITS_DEF-1:0]   killer_first;
    logic [MOVE_BITS_DEF-1:0]   killer_second;
    logic                       halved;
    logic                       cfg_we = 1'b0;
    logic [LIMIT_W-1:0]         cfg_wdata = '0;
    int                         errors;
    int                         pending;
    int                         results_seen;

    // Hot entries so that scores build up and killers repeat
    logic [PIECE_W-1:0]         hot_piece [8];
    logic [SQ_W-1:0]            hot_square [8];
    logic [PLY_W-1:0]           hot_ply [4];
    logic [MOVE_BITS_DEF-1:0]   hot_move [6];
    int                         send_calm = 0;

    history_killer_table DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .kind           (word_kind),
        .piece          (piece),
        .to_square      (to_square),
        .move_code      (move_code),
        .depth          (depth),
        .ply            (ply),
        .is_quiet       (is_quiet),
        .empty          (empty),
        .pop            (pop),
        .score          (score),
        .killer_first   (killer_first),
        .killer_second  (killer_second),
        .halved         (halved),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    history_killer_table_check table_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .kind           (word_kind),
        .piece          (piece),
        .to_square      (to_square),
        .move_code      (move_code),
        .depth          (depth),
        .ply            (ply),
        .is_quiet       (is_quiet),
        .empty          (empty),
        .pop            (pop),
        .score          (score),
        .killer_first   (killer_first),
        .killer_second  (killer_second),
        .halved         (halved),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .errors         (errors),
        .pending        (pending),
        .results_seen   (results_seen)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // Mostly short gaps, a few long ones, and stretches with none
    task automatic next_gap(inout int calm_left, output int gap);
        int r;
        gap = 0;
        if (calm_left > 0)
            calm_left--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                calm_left = $urandom_range(30, 120);
            else if (r < 55)
                gap = 0;
            else if (r < 85)
                gap = $urandom_range(1, 3);
            else if (r < 97)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(20, 60);
        end
    endtask

    // Result side: random pops, plus one long hold to back the block up
    initial
    begin
        int gap;
        int calm_left;
        int hold_left;
        bit held_once;
        gap       = 0;
        calm_left = 0;
        hold_left = 0;
        held_once = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (!held_once && results_seen >= HOLD_AFTER)
            begin
                held_once = 1;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end
            else if (gap > 0)
            begin
                pop <= 1'b0;
                gap--;
            end
            else
            begin
                pop <= 1'b1;
                next_gap(calm_left, gap);
            end
        end
    end

    // Offer one word and wait until it is taken; entered right after a taking edge
    task automatic send_word(
        input kind_t                    op,
        input logic [PIECE_W-1:0]       pc,
        input logic [SQ_W-1:0]          sq,
        input logic [MOVE_BITS_DEF-1:0] mv,
        input logic [DEPTH_W-1:0]       dp,
        input logic [PLY_W-1:0]         pl,
        input logic                     quiet
    );
        int gap;
        next_gap(send_calm, gap);
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        word_kind <= op;
        piece     <= pc;
        to_square <= sq;
        move_code <= mv;
        depth     <= dp;
        ply       <= pl;
        is_quiet  <= quiet;
        push      <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Stop offering and wait for every result, then let any sweep finish
    task automatic quiesce(input int settle);
        @(negedge clk);
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(negedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic pick_hot_sets();
        foreach (hot_piece[i])
        begin
            hot_piece[i]  = PIECE_W'($urandom_range(0, PIECE_KINDS_DEF - 1));
            hot_square[i] = SQ_W'($urandom_range(0, SQUARES_DEF - 1));
        end
        foreach (hot_ply[i])
            hot_ply[i] = PLY_W'($urandom_range(0, PLY_COUNT_DEF - 1));
        foreach (hot_move[i])
            hot_move[i] = MOVE_BITS_DEF'($urandom_range(0, 65535));
    endtask

    // Search-like traffic on hot entries with some noise; drain midway if asked
    task automatic run_random(input int count, input int drain_at);
        kind_t                      op;
        logic [PIECE_W-1:0]         pc;
        logic [SQ_W-1:0]            sq;
        logic [MOVE_BITS_DEF-1:0]   mv;
        logic [DEPTH_W-1:0]         dp;
        logic [PLY_W-1:0]           pl;
        logic                       quiet;
        int                         r;
        logic [2:0]                 h;
        pick_hot_sets();
        for (int n = 0; n < count; n++)
        begin
            if (n == drain_at)
                quiesce(0);
            r = $urandom_range(0, 99);
            if (r < 3)
                op = KIND_CLEAR;
            else if (r < 45)
                op = KIND_REWARD;
            else if (r < 78)
                op = KIND_PENALTY;
            else
                op = KIND_READ;
            if ($urandom_range(0, 99) < 75)
            begin
                h  = 3'($urandom_range(0, 7));
                pc = hot_piece[h];
                sq = hot_square[h];
            end
            else
            begin
                pc = PIECE_W'($urandom_range(0, 15));
                sq = SQ_W'($urandom_range(0, 63));
            end
            if ($urandom_range(0, 99) < 70)
                pl = hot_ply[2'($urandom_range(0, 3))];
            else
                pl = PLY_W'($urandom_range(0, 63));
            if ($urandom_range(0, 99) < 60)
                mv = hot_move[3'($urandom_range(0, 5))];
            else
                mv = MOVE_BITS_DEF'($urandom_range(0, 65535));
            r = $urandom_range(0, 99);
            if (r < 50)
                dp = DEPTH_W'($urandom_range(0, 63));
            else if (r < 80)
                dp = DEPTH_W'($urandom_range(40, 63));
            else
                dp = DEPTH_W'($urandom_range(0, 8));
            quiet = $urandom_range(0, 99) < 85;
            send_word(op, pc, sq, mv, dp, pl, quiet);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset limit
        send_word(KIND_READ,    4'd0,  6'd0,  16'h0000, 6'd0,  6'd0,  1'b0);
        send_word(KIND_REWARD,  4'd11, 6'd63, 16'hFFFF, 6'd63, 6'd63, 1'b1);
        send_word(KIND_REWARD,  4'd11, 6'd63, 16'hFFFF, 6'd63, 6'd63, 1'b1);
        send_word(KIND_REWARD,  4'd11, 6'd63, 16'h0001, 6'd1,  6'd63, 1'b1);
        send_word(KIND_REWARD,  4'd11, 6'd63, 16'h0001, 6'd63, 6'd63, 1'b1);
        // capture move: reported like a read
        send_word(KIND_REWARD,  4'd11, 6'd63, 16'h1234, 6'd63, 6'd63, 1'b0);
        send_word(KIND_PENALTY, 4'd0,  6'd0,  16'h0000, 6'd63, 6'd0,  1'b1);
        send_word(KIND_PENALTY, 4'd0,  6'd0,  16'h0000, 6'd0,  6'd0,  1'b0);
        repeat (4)
            send_word(KIND_PENALTY, 4'd0, 6'd0, 16'h8000, 6'd63, 6'd0, 1'b1);
        // piece off the table: no score, killers still move
        send_word(KIND_REWARD,  4'd12, 6'd5,  16'hAAAA, 6'd63, 6'd7,  1'b1);
        send_word(KIND_PENALTY, 4'd15, 6'd63, 16'h0000, 6'd63, 6'd7,  1'b1);
        send_word(KIND_READ,    4'd13, 6'd21, 16'h0000, 6'd0,  6'd7,  1'b0);
        send_word(KIND_REWARD,  4'd3,  6'd42, 16'h5555, 6'd0,  6'd7,  1'b1);
        send_word(KIND_READ,    4'd11, 6'd63, 16'h0000, 6'd0,  6'd63, 1'b1);
        send_word(KIND_CLEAR,   4'd11, 6'd63, 16'hFFFF, 6'd63, 6'd63, 1'b1);
        send_word(KIND_READ,    4'd11, 6'd63, 16'h0000, 6'd0,  6'd63, 1'b0);
        send_word(KIND_READ,    4'd3,  6'd42, 16'h0000, 6'd0,  6'd7,  1'b0);
        // same move as a cleared first killer: no shift
        send_word(KIND_REWARD,  4'd0,  6'd0,  16'h0000, 6'd5,  6'd0,  1'b1);
        quiesce(SWEEP_WAIT);

        // Random phases over a range of limits, extremes included
        run_random(600, 300);
        quiesce(SWEEP_WAIT);
        write_limit(LIMIT_W'(2097151));
        run_random(300, -1);
        quiesce(SWEEP_WAIT);
        write_limit(LIMIT_W'(0));
        run_random(40, -1);
        quiesce(SWEEP_WAIT);
        write_limit(LIMIT_W'(1));
        run_random(40, -1);
        quiesce(SWEEP_WAIT);
        write_limit(LIMIT_W'(1048576));
        run_random(200, -1);
        quiesce(SWEEP_WAIT);
        write_limit(LIMIT_W'(300));
        run_random(300, -1);
        quiesce(SWEEP_WAIT);

        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
